>>> hdl/mcrg_pkg.sv
// ----------------------------------------------------------------------------
// mcrg_pkg
// Shared constants, codes, control structs and the full-scale divide for the
// multitouch contact report generator.
// ----------------------------------------------------------------------------
package mcrg_pkg;

  // contact table size
  localparam int MaxContacts = 10;
  localparam int SlotW       = (MaxContacts > 1) ? $clog2(MaxContacts) : 1;
  localparam int CntW        = $clog2(MaxContacts + 1);

  // field widths
  localparam int FuncW    = 1;
  localparam int ActW     = 2;
  localparam int IdW      = 8;
  localparam int PosW     = 16;
  localparam int ActCntW  = 4;
  localparam int RotW     = 2;
  localparam int ProdW    = 2 * PosW;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 16;
  localparam int PointW   = 2 * PosW;

  // constants
  localparam logic [PosW-1:0] FullScale   = 16'hFFFF;
  localparam logic [PosW-1:0] CoordMaxRst = 16'd32767;

  // function codes
  localparam logic [FuncW-1:0] FuncTouch   = 1'b0;
  localparam logic [FuncW-1:0] FuncRelease = 1'b1;

  // touch action codes
  localparam logic [ActW-1:0] ActDown = 2'd0;
  localparam logic [ActW-1:0] ActMove = 2'd1;
  localparam logic [ActW-1:0] ActUp   = 2'd2;

  // rotation codes
  localparam logic [RotW-1:0] Rot0   = 2'd0;
  localparam logic [RotW-1:0] Rot90  = 2'd1;
  localparam logic [RotW-1:0] Rot180 = 2'd2;
  localparam logic [RotW-1:0] Rot270 = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgRotation = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgCoordMax = 1'd1;

  // commands from the sequencer to the contact order unit
  typedef struct packed {
    logic             wr;        // mark slot valid and store key as its id
    logic             clr;       // mark slot invalid
    logic             load_all;  // walk set = all valid slots
    logic             load_oth;  // walk set = valid slots not matching key
    logic             pop;       // drop the picked slot from the walk set
    logic [SlotW-1:0] slot;
    logic [IdW-1:0]   key;
  } ord_cmd_t;

  // status from the contact order unit
  typedef struct packed {
    logic             hit;
    logic [SlotW-1:0] hit_idx;
    logic             free;
    logic [SlotW-1:0] free_idx;
    logic             any_valid;
    logic             others;
    logic             rem_any;
    logic [SlotW-1:0] pick_idx;
    logic [IdW-1:0]   pick_id;
    logic [CntW-1:0]  count;
  } ord_sts_t;

  // floor(p / 65535) for p below 2^32: p = q0*65535 + (q0 + lo)
  function automatic logic [PosW-1:0] div_full_scale(input logic [ProdW-1:0] p);
    logic [PosW:0] s;
    logic [PosW:0] q;
    s = {1'b0, p[ProdW-1:PosW]} + {1'b0, p[PosW-1:0]};
    q = {1'b0, p[ProdW-1:PosW]};
    if (s >= {1'b0, FullScale}) q = q + 1'b1;
    if (s >= {FullScale, 1'b0}) q = q + 1'b1;
    return q[PosW-1:0];
  endfunction

endpackage

>>> hdl/mcrg_if.sv
// ----------------------------------------------------------------------------
// mcrg_if
// Valid/ready channels for touch events and contact reports.
// ----------------------------------------------------------------------------
interface mcrg_evt_if;
  logic                          valid;
  logic                          ready;
  logic [mcrg_pkg::FuncW-1:0]    func;
  logic [mcrg_pkg::ActW-1:0]     action;
  logic [mcrg_pkg::IdW-1:0]      contact_id;
  logic [mcrg_pkg::PosW-1:0]     pos_x;
  logic [mcrg_pkg::PosW-1:0]     pos_y;

  modport source (output valid, func, action, contact_id, pos_x, pos_y, input ready);
  modport sink   (input valid, func, action, contact_id, pos_x, pos_y, output ready);
endinterface

interface mcrg_rpt_if;
  logic                          valid;
  logic                          ready;
  logic                          tip;
  logic [mcrg_pkg::IdW-1:0]      report_id;
  logic [mcrg_pkg::PosW-1:0]     hid_x;
  logic [mcrg_pkg::PosW-1:0]     hid_y;
  logic [mcrg_pkg::ActCntW-1:0]  active_count;
  logic                          last;

  modport source (output valid, tip, report_id, hid_x, hid_y, active_count, last,
                  input ready);
  modport sink   (input valid, tip, report_id, hid_x, hid_y, active_count, last,
                  output ready);
endinterface

>>> hdl/multitouch_contact_report_generator.sv
// ----------------------------------------------------------------------------
// multitouch_contact_report_generator
// Turns touch events into hid contact reports and keeps the active contact
// table; contact points live in a small ram, ids and valid flags in flops.
//
//   channel  dir  handshake     payload
//   evt_i    in   valid/ready   func, action, contact_id, pos_x, pos_y
//   rpt_o    out  valid/ready   tip, report_id, hid_x, hid_y, active_count, last
//   cfg      in   cfg_we_i      cfg_idx_i, cfg_data_i (rotation, coord_max)
//
// A touch event reaches its first report through accept, multiply, divide,
// table update and report, then each further contact takes a point ram read
// and a report load. Release-all takes a read and a load per contact.
// One event is in flight at a time; evt_i.ready is high only while idle.
// A stalled rpt_o holds the sequencer in the report-load step.
// Reset empties the table and restores rotation 0 and coord_max 32767.
// ----------------------------------------------------------------------------
module multitouch_contact_report_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mcrg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mcrg_pkg::CfgDataW-1:0] cfg_data_i,
  mcrg_evt_if.sink                      evt_i,
  mcrg_rpt_if.source                    rpt_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCALE    = 3'd1;
  localparam logic [2:0] S_UPD      = 3'd2;
  localparam logic [2:0] S_HEAD     = 3'd3;
  localparam logic [2:0] S_WALK_RD  = 3'd4;
  localparam logic [2:0] S_WALK_OUT = 3'd5;

  logic [2:0]                    state_q, state_d;
  logic [mcrg_pkg::RotW-1:0]     rot_q;
  logic [mcrg_pkg::PosW-1:0]     cmax_q;
  logic [mcrg_pkg::ActW-1:0]     act_q;
  logic [mcrg_pkg::IdW-1:0]      cur_id_q;
  logic                          rel_q, rel_d;
  logic [mcrg_pkg::IdW-1:0]      rid_q, rid_d;

  logic                          evt_fire, scale_start, scale_done;
  logic [mcrg_pkg::PosW-1:0]     hid_x, hid_y;

  mcrg_pkg::ord_cmd_t            cmd;
  mcrg_pkg::ord_sts_t            sts;

  logic                          ram_we, ram_re;
  logic [mcrg_pkg::PointW-1:0]   ram_rdata;

  logic                          out_valid_q, out_free, ld;
  logic                          ld_tip, ld_last;
  logic [mcrg_pkg::IdW-1:0]      ld_id;
  logic [mcrg_pkg::PosW-1:0]     ld_x, ld_y;
  logic                          tip_q, last_q;
  logic [mcrg_pkg::IdW-1:0]      rpt_id_q;
  logic [mcrg_pkg::PosW-1:0]     hx_q, hy_q;
  logic [mcrg_pkg::ActCntW-1:0]  cnt_q;

  assign evt_i.ready = (state_q == S_IDLE);
  assign evt_fire    = evt_i.valid && evt_i.ready;
  assign scale_start = evt_fire && (evt_i.func == mcrg_pkg::FuncTouch) &&
                       (evt_i.action == mcrg_pkg::ActDown ||
                        evt_i.action == mcrg_pkg::ActMove ||
                        evt_i.action == mcrg_pkg::ActUp);
  assign out_free    = !out_valid_q || rpt_o.ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q  <= mcrg_pkg::Rot0;
      cmax_q <= mcrg_pkg::CoordMaxRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mcrg_pkg::CfgRotation: rot_q  <= cfg_data_i[mcrg_pkg::RotW-1:0];
        mcrg_pkg::CfgCoordMax: cmax_q <= cfg_data_i[mcrg_pkg::PosW-1:0];
        default: ;
      endcase
    end
  end

  // position scaling
  mcrg_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (scale_start),
    .rot_i       (rot_q),
    .coord_max_i (cmax_q),
    .pos_x_i     (evt_i.pos_x),
    .pos_y_i     (evt_i.pos_y),
    .done_o      (scale_done),
    .hid_x_o     (hid_x),
    .hid_y_o     (hid_y)
  );

  // contact ids, valid flags and walk order
  mcrg_order u_order (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

  // stored contact points
  mcrg_ram #(
    .Depth (mcrg_pkg::MaxContacts),
    .Width (mcrg_pkg::PointW)
  ) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cmd.slot),
    .wdata_i ({hid_x, hid_y}),
    .re_i    (ram_re),
    .raddr_i (sts.pick_idx),
    .rdata_o (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_d  = state_q;
    rel_d    = rel_q;
    rid_d    = rid_q;
    cmd      = '0;
    cmd.key  = cur_id_q;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    ld       = 1'b0;
    ld_tip   = 1'b1;
    ld_id    = cur_id_q;
    ld_x     = hid_x;
    ld_y     = hid_y;
    ld_last  = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (evt_fire) begin
          if (evt_i.func == mcrg_pkg::FuncRelease) begin
            if (sts.any_valid) begin
              cmd.load_all = 1'b1;
              rel_d        = 1'b1;
              state_d      = S_WALK_RD;
            end
          end else if (scale_start) begin
            state_d = S_SCALE;
          end
        end
      end
      S_SCALE: begin
        if (scale_done) state_d = S_UPD;
      end
      S_UPD: begin
        if (act_q == mcrg_pkg::ActUp) begin
          cmd.clr  = sts.hit;
          cmd.slot = sts.hit_idx;
        end else begin
          cmd.wr   = sts.hit || sts.free;
          cmd.slot = sts.hit ? sts.hit_idx : sts.free_idx;
          ram_we   = sts.hit || sts.free;
        end
        state_d = S_HEAD;
      end
      S_HEAD: begin
        if (out_free) begin
          ld      = 1'b1;
          ld_tip  = (act_q != mcrg_pkg::ActUp);
          ld_last = (act_q == mcrg_pkg::ActMove) || !sts.others;
          if (!ld_last) begin
            cmd.load_oth = 1'b1;
            rel_d        = 1'b0;
            state_d      = S_WALK_RD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_WALK_RD: begin
        cmd.pop  = 1'b1;
        cmd.clr  = rel_q;
        cmd.slot = sts.pick_idx;
        ram_re   = 1'b1;
        rid_d    = sts.pick_id;
        state_d  = S_WALK_OUT;
      end
      S_WALK_OUT: begin
        if (out_free) begin
          ld      = 1'b1;
          ld_tip  = !rel_q;
          ld_id   = rid_q;
          ld_x    = ram_rdata[mcrg_pkg::PointW-1:mcrg_pkg::PosW];
          ld_y    = ram_rdata[mcrg_pkg::PosW-1:0];
          ld_last = !sts.rem_any;
          state_d = sts.rem_any ? S_WALK_RD : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rel_q   <= rel_d;
    end
  end

  // event fields and walk id
  always_ff @(posedge clk_i) begin
    if (evt_fire) begin
      act_q    <= evt_i.action;
      cur_id_q <= evt_i.contact_id;
    end
    rid_q <= rid_d;
  end

  // report output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ld) begin
      out_valid_q <= 1'b1;
    end else if (rpt_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      tip_q    <= ld_tip;
      rpt_id_q <= ld_id;
      hx_q     <= ld_x;
      hy_q     <= ld_y;
      cnt_q    <= mcrg_pkg::ActCntW'(sts.count);
      last_q   <= ld_last;
    end
  end

  assign rpt_o.valid        = out_valid_q;
  assign rpt_o.tip          = tip_q;
  assign rpt_o.report_id    = rpt_id_q;
  assign rpt_o.hid_x        = hx_q;
  assign rpt_o.hid_y        = hy_q;
  assign rpt_o.active_count = cnt_q;
  assign rpt_o.last         = last_q;

  // a walk step always has a contact to pick
  a_walk_has_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK_RD) |-> sts.rem_any)
    else $error("walk step with empty walk set");

  // scaled point arrives only while the sequencer waits for it
  a_scale_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scale_done |-> (state_q == S_SCALE))
    else $error("scaled point arrived outside the scale wait");

  // report load of a walk always follows its ram read
  a_walk_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK_OUT) |->
      ($past(state_q) == S_WALK_RD || $past(state_q) == S_WALK_OUT))
    else $error("walk report without a point read");

endmodule

>>> hdl/mcrg_ram.sv
// ----------------------------------------------------------------------------
// mcrg_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mcrg_ram #(
  parameter int Depth = 10,
  parameter int Width = 32,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/mcrg_scale.sv
// ----------------------------------------------------------------------------
// mcrg_scale
// Rotates a display position and scales it to the hid range in two stages:
// multiply by coord_max, then divide by full scale.
// ----------------------------------------------------------------------------
module mcrg_scale (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [mcrg_pkg::RotW-1:0]  rot_i,
  input  logic [mcrg_pkg::PosW-1:0]  coord_max_i,
  input  logic [mcrg_pkg::PosW-1:0]  pos_x_i,
  input  logic [mcrg_pkg::PosW-1:0]  pos_y_i,
  output logic                       done_o,
  output logic [mcrg_pkg::PosW-1:0]  hid_x_o,
  output logic [mcrg_pkg::PosW-1:0]  hid_y_o
);

  logic [mcrg_pkg::PosW-1:0]  rx, ry;
  logic [mcrg_pkg::ProdW-1:0] prod_x_d, prod_y_d;
  logic [mcrg_pkg::ProdW-1:0] prod_x_q, prod_y_q;
  logic [mcrg_pkg::PosW-1:0]  hid_x_q, hid_y_q;
  logic                       stg1_q, done_q;

  // display rotation
  always_comb begin
    case (rot_i)
      mcrg_pkg::Rot90: begin
        rx = pos_y_i;
        ry = mcrg_pkg::FullScale - pos_x_i;
      end
      mcrg_pkg::Rot180: begin
        rx = mcrg_pkg::FullScale - pos_x_i;
        ry = mcrg_pkg::FullScale - pos_y_i;
      end
      mcrg_pkg::Rot270: begin
        rx = mcrg_pkg::FullScale - pos_y_i;
        ry = pos_x_i;
      end
      default: begin
        rx = pos_x_i;
        ry = pos_y_i;
      end
    endcase
  end

  assign prod_x_d = rx * coord_max_i;
  assign prod_y_d = ry * coord_max_i;

  // stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg1_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      stg1_q <= start_i;
      done_q <= stg1_q;
    end
  end

  // product and quotient registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
    end
    if (stg1_q) begin
      hid_x_q <= mcrg_pkg::div_full_scale(prod_x_q);
      hid_y_q <= mcrg_pkg::div_full_scale(prod_y_q);
    end
  end

  assign done_o  = done_q;
  assign hid_x_o = hid_x_q;
  assign hid_y_o = hid_y_q;

endmodule

>>> hdl/mcrg_order.sv
// ----------------------------------------------------------------------------
// mcrg_order
// Contact ids and valid flags, id lookup, free slot search and the
// ascending-id walk over a set of slots.
// ----------------------------------------------------------------------------
module mcrg_order (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mcrg_pkg::ord_cmd_t cmd_i,
  output mcrg_pkg::ord_sts_t sts_o
);

  localparam int N = mcrg_pkg::MaxContacts;

  logic [N-1:0]                 valid_q;
  logic [mcrg_pkg::IdW-1:0]     id_q [N];
  logic [N-1:0][N-1:0]          lt_q;
  logic [N-1:0][N-1:0]          lt_d;
  logic [N-1:0]                 rem_q;
  logic [N-1:0]                 hit_vec;
  logic [N-1:0]                 sel;
  logic [mcrg_pkg::SlotW-1:0]   hit_idx, free_idx, pick_idx;
  logic [mcrg_pkg::IdW-1:0]     pick_id;
  logic [mcrg_pkg::CntW-1:0]    count;

  // id lookup against the key
  always_comb begin
    for (int i = 0; i < N; i++) begin
      hit_vec[i] = valid_q[i] && (id_q[i] == cmd_i.key);
    end
  end

  // pairwise id order, registered
  always_comb begin
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        lt_d[i][j] = id_q[i] < id_q[j];
      end
    end
  end

  // smallest id of the walk set
  always_comb begin
    for (int i = 0; i < N; i++) begin
      sel[i] = rem_q[i];
      for (int j = 0; j < N; j++) begin
        if (j != i && rem_q[j] && !lt_q[i][j]) sel[i] = 1'b0;
      end
    end
  end

  // encoders and count
  always_comb begin
    hit_idx  = '0;
    pick_idx = '0;
    pick_id  = '0;
    free_idx = '0;
    count    = '0;
    for (int i = 0; i < N; i++) begin
      if (hit_vec[i]) hit_idx = hit_idx | mcrg_pkg::SlotW'(i);
      if (sel[i]) begin
        pick_idx = pick_idx | mcrg_pkg::SlotW'(i);
        pick_id  = pick_id | id_q[i];
      end
      count = count + mcrg_pkg::CntW'(valid_q[i]);
    end
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_idx = mcrg_pkg::SlotW'(i);
    end
  end

  // valid flags, walk set and order matrix
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rem_q   <= '0;
      lt_q    <= '0;
    end else begin
      lt_q <= lt_d;
      if (cmd_i.wr)  valid_q[cmd_i.slot] <= 1'b1;
      if (cmd_i.clr) valid_q[cmd_i.slot] <= 1'b0;
      if (cmd_i.load_all) begin
        rem_q <= valid_q;
      end else if (cmd_i.load_oth) begin
        rem_q <= valid_q & ~hit_vec;
      end else if (cmd_i.pop) begin
        rem_q <= rem_q & ~sel;
      end
    end
  end

  // contact ids
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) id_q[cmd_i.slot] <= cmd_i.key;
  end

  assign sts_o.hit       = |hit_vec;
  assign sts_o.hit_idx   = hit_idx;
  assign sts_o.free      = ~&valid_q;
  assign sts_o.free_idx  = free_idx;
  assign sts_o.any_valid = |valid_q;
  assign sts_o.others    = |(valid_q & ~hit_vec);
  assign sts_o.rem_any   = |rem_q;
  assign sts_o.pick_idx  = pick_idx;
  assign sts_o.pick_id   = pick_id;
  assign sts_o.count     = count;

  // walk set only holds live contacts
  a_rem_in_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q & ~valid_q) == '0)
    else $error("walk set holds an invalid slot");

  // exactly one smallest id while walking
  a_pick_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q != '0) |-> $onehot(sel))
    else $error("walk pick is not unique");

endmodule

>>> tb/multitouch_contact_report_generator_tb.sv
// ----------------------------------------------------------------------------
// multitouch_contact_report_generator_tb
// Drives touch events and release-all commands into the report generator and
// checks every contact report beat against a local model of the contact table,
// rotation and hid scaling. A short directed table covers the corner cases,
// then random phases run under several rotation and coord_max settings with
// random idle bursts on both channels and one long report back-pressure hold.
// ----------------------------------------------------------------------------
module multitouch_contact_report_generator_tb;

  localparam int          PhaseItems  = 48;
  localparam int          NumPhases   = 5;
  localparam int          DrainCycles = 64;
  localparam int          HoldCycles  = 300;
  localparam int          CycleLimit  = 200000;
  localparam int          DirRows     = 22;
  localparam logic [mcrg_pkg::ActW-1:0] ActIgnored = 2'd3;

  typedef struct packed {
    logic [mcrg_pkg::FuncW-1:0] func;
    logic [mcrg_pkg::ActW-1:0]  action;
    logic [mcrg_pkg::IdW-1:0]   contact_id;
    logic [mcrg_pkg::PosW-1:0]  pos_x;
    logic [mcrg_pkg::PosW-1:0]  pos_y;
  } touch_evt_t;

  typedef struct packed {
    logic                         tip;
    logic [mcrg_pkg::IdW-1:0]     report_id;
    logic [mcrg_pkg::PosW-1:0]    hid_x;
    logic [mcrg_pkg::PosW-1:0]    hid_y;
    logic [mcrg_pkg::ActCntW-1:0] active_count;
    logic                         last;
  } contact_rpt_t;

  // directed row: event, plus the first report where it is obvious by hand
  typedef struct packed {
    touch_evt_t   ev;
    logic         typed;
    contact_rpt_t want;
  } dir_row_t;

  localparam dir_row_t DirTable [0:DirRows-1] = '{
    // release-all on an empty table: no reports
    '{'{mcrg_pkg::FuncRelease, mcrg_pkg::ActDown, 8'd0, 16'd0, 16'd0}, 1'b0, '0},
    // up on unknown id with empty table
    '{'{mcrg_pkg::FuncTouch, mcrg_pkg::ActUp, 8'd5, 16'd0, 16'hFFFF}, 1'b1,
      '{1'b0, 8'd5, 16'd0, 16'd32767, 4'd0, 1'b1}},
    // first down, origin
    '{'{mcrg_pkg::FuncTouch, mcrg_pkg::ActDown, 8'd0, 16'd0, 16'd0}, 1'b1,
      '{1'b1, 8'd0, 16'd0, 16'd0, 4'd1, 1'b1}},
    // down at the far corner, id 0 follows
    '{'{mcrg_pkg::FuncTouch, mcrg_pkg::ActDown, 8'd255, 16'hFFFF, 16'hFFFF}, 1'b1,
      '{1'b1, 8'd255, 16'd32767, 16'd32767, 4'd2, 1'b0}},
    '{'{mcrg_pkg::FuncTouch, mcrg_pkg::ActMove, 8'd0, 16'd12345, 16'd54321}, 1'b0, '0},
    // reserved action code: ignored
    '{'{mcrg_pkg::FuncTouch, ActIgnored, 8'd7, 16'hAAAA, 16'h5555}, 1'b0, '0},
    // move on unknown id inserts
    '{'{mcrg_pkg::FuncTouch, mcrg_pkg::ActMove, 8'd9, 16'h5555, 16'hAAAA}, 1'b0, '0},
    // fill the table
    '{'{mcrg_pkg::FuncTouch, mcrg_pkg::ActDown, 8'd1, 16'd100, 16'd65000}, 1'b0, '0},
    '{'{mcrg_pkg::FuncTouch, mcrg_pkg::ActDown, 8'd2, 16'd20000, 16'd3}, 1'b0, '0},
    '{'{mcrg_pkg::FuncTouch, mcrg_pkg::ActDown, 8'd3, 16'd32768, 16'd32767}, 1'b0, '0},
    '{'{mcrg_pkg::FuncTouch, mcrg_pkg::ActDown, 8'd4, 16'd1, 16'd65534}, 1'b0, '0},
    '{'{mcrg_pkg::FuncTouch, mcrg_pkg::ActDown, 8'd5, 16'h8001, 16'h7FFE}, 1'b0, '0},
    '{'{mcrg_pkg::FuncTouch, mcrg_pkg::ActDown, 8'd6, 16'd4660, 16'd22136}, 1'b0, '0},
    '{'{mcrg_pkg::FuncTouch, mcrg_pkg::ActDown, 8'd7, 16'd60000, 16'd50000}, 1'b0, '0},
    // down on new id with full table: not stored, all ten follow
    '{'{mcrg_pkg::FuncTouch, mcrg_pkg::ActDown, 8'd100, 16'd0, 16'd0}, 1'b1,
      '{1'b1, 8'd100, 16'd0, 16'd0, 4'd10, 1'b0}},
    // move on new id with full table
    '{'{mcrg_pkg::FuncTouch, mcrg_pkg::ActMove, 8'd101, 16'd1000, 16'd2000}, 1'b0, '0},
    // down on existing id updates in place
    '{'{mcrg_pkg::FuncTouch, mcrg_pkg::ActDown, 8'd3, 16'd40000, 16'd100}, 1'b0, '0},
    '{'{mcrg_pkg::FuncTouch, mcrg_pkg::ActUp, 8'd255, 16'd30000, 16'd30000}, 1'b0, '0},
    // up on unknown id with contacts active
    '{'{mcrg_pkg::FuncTouch, mcrg_pkg::ActUp, 8'd200, 16'd1, 16'd1}, 1'b0, '0},
    '{'{mcrg_pkg::FuncRelease, ActIgnored, 8'hFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
    '{'{mcrg_pkg::FuncRelease, mcrg_pkg::ActMove, 8'd0, 16'd0, 16'd0}, 1'b0, '0},
    '{'{mcrg_pkg::FuncTouch, mcrg_pkg::ActMove, 8'd42, 16'd100, 16'd200}, 1'b0, '0}
  };

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [mcrg_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [mcrg_pkg::CfgDataW-1:0] cfg_data_i;

  mcrg_evt_if evt ();
  mcrg_rpt_if rpt ();

  multitouch_contact_report_generator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .evt_i      (evt),
    .rpt_o      (rpt)
  );

  // contact table and register shadow
  logic                      tbl_valid [mcrg_pkg::MaxContacts] = '{default: 1'b0};
  logic [mcrg_pkg::IdW-1:0]  tbl_id    [mcrg_pkg::MaxContacts];
  logic [mcrg_pkg::PosW-1:0] tbl_x     [mcrg_pkg::MaxContacts];
  logic [mcrg_pkg::PosW-1:0] tbl_y     [mcrg_pkg::MaxContacts];
  logic [mcrg_pkg::RotW-1:0] cur_rot  = mcrg_pkg::Rot0;
  logic [mcrg_pkg::PosW-1:0] cur_cmax = mcrg_pkg::CoordMaxRst;

  contact_rpt_t pending_reports [$];
  int           mismatches  = 0;
  int           cycle_count = 0;
  bit           gaps_on     = 1'b1;
  bit           hold_req    = 1'b0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("multitouch_contact_report_generator verification failed");
    $finish;
  end

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("[%0d] mismatch %s: got %0d want %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  // floor(r * coord_max / 65535)
  function automatic logic [mcrg_pkg::PosW-1:0] hid_scale(
      input logic [mcrg_pkg::PosW-1:0] r);
    logic [mcrg_pkg::ProdW-1:0] prod;
    prod = {16'b0, r} * {16'b0, cur_cmax};
    return mcrg_pkg::PosW'(prod / {16'b0, mcrg_pkg::FullScale});
  endfunction

  function automatic int slot_of(input logic [mcrg_pkg::IdW-1:0] id);
    for (int i = 0; i < mcrg_pkg::MaxContacts; i++)
      if (tbl_valid[i] && tbl_id[i] == id) return i;
    return -1;
  endfunction

  function automatic logic [mcrg_pkg::ActCntW-1:0] live_count();
    logic [mcrg_pkg::ActCntW-1:0] c;
    c = '0;
    for (int i = 0; i < mcrg_pkg::MaxContacts; i++)
      if (tbl_valid[i]) c++;
    return c;
  endfunction

  // update the table for one accepted event and queue the reports it causes
  function automatic int touch_to_reports(input touch_evt_t ev);
    logic [mcrg_pkg::PosW-1:0]    rx, ry, hx, hy;
    logic [mcrg_pkg::ActCntW-1:0] cnt;
    int                           s, n;
    n = 0;
    // release-all: lift contacts in ascending id order, count falling
    if (ev.func == mcrg_pkg::FuncRelease) begin
      for (int k = 0; k < 256; k++) begin
        s = slot_of(k[mcrg_pkg::IdW-1:0]);
        if (s >= 0) begin
          tbl_valid[s] = 1'b0;
          pending_reports.push_back('{1'b0, tbl_id[s], tbl_x[s], tbl_y[s],
                                      live_count(), 1'b0});
          n++;
        end
      end
      if (n > 0) pending_reports[pending_reports.size()-1].last = 1'b1;
      return n;
    end
    if (ev.action == ActIgnored) return 0;
    // rotate, then scale
    case (cur_rot)
      mcrg_pkg::Rot90: begin
        rx = ev.pos_y;
        ry = mcrg_pkg::FullScale - ev.pos_x;
      end
      mcrg_pkg::Rot180: begin
        rx = mcrg_pkg::FullScale - ev.pos_x;
        ry = mcrg_pkg::FullScale - ev.pos_y;
      end
      mcrg_pkg::Rot270: begin
        rx = mcrg_pkg::FullScale - ev.pos_y;
        ry = ev.pos_x;
      end
      default: begin
        rx = ev.pos_x;
        ry = ev.pos_y;
      end
    endcase
    hx = hid_scale(rx);
    hy = hid_scale(ry);
    // table update
    s = slot_of(ev.contact_id);
    if (ev.action == mcrg_pkg::ActUp) begin
      if (s >= 0) tbl_valid[s] = 1'b0;
    end else begin
      if (s < 0)
        for (int i = mcrg_pkg::MaxContacts - 1; i >= 0; i--)
          if (!tbl_valid[i]) s = i;
      if (s >= 0) begin
        tbl_valid[s] = 1'b1;
        tbl_id[s]    = ev.contact_id;
        tbl_x[s]     = hx;
        tbl_y[s]     = hy;
      end
    end
    cnt = live_count();
    pending_reports.push_back('{ev.action != mcrg_pkg::ActUp, ev.contact_id, hx, hy,
                                cnt, 1'b0});
    n = 1;
    // down and up also report every other active contact
    if (ev.action == mcrg_pkg::ActDown || ev.action == mcrg_pkg::ActUp) begin
      for (int k = 0; k < 256; k++) begin
        s = (k[mcrg_pkg::IdW-1:0] == ev.contact_id) ? -1 :
            slot_of(k[mcrg_pkg::IdW-1:0]);
        if (s >= 0) begin
          pending_reports.push_back('{1'b1, tbl_id[s], tbl_x[s], tbl_y[s], cnt, 1'b0});
          n++;
        end
      end
    end
    pending_reports[pending_reports.size()-1].last = 1'b1;
    return n;
  endfunction

  function automatic logic [mcrg_pkg::IdW-1:0] pick_live_id();
    logic [mcrg_pkg::IdW-1:0] ids [$];
    for (int i = 0; i < mcrg_pkg::MaxContacts; i++)
      if (tbl_valid[i]) ids.push_back(tbl_id[i]);
    if (ids.size() == 0) return mcrg_pkg::IdW'($urandom_range(0, 255));
    return ids[$urandom_range(0, ids.size() - 1)];
  endfunction

  function automatic logic [mcrg_pkg::PosW-1:0] rand_pos();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return mcrg_pkg::FullScale;
      default: return mcrg_pkg::PosW'($urandom_range(0, 65535));
    endcase
  endfunction

  // mostly well-formed touch traffic on live ids, some noise
  function automatic touch_evt_t rand_event();
    touch_evt_t ev;
    int         pick;
    ev.func       = mcrg_pkg::FuncTouch;
    ev.action     = mcrg_pkg::ActW'($urandom_range(0, 3));
    ev.contact_id = mcrg_pkg::IdW'($urandom_range(0, 255));
    ev.pos_x      = rand_pos();
    ev.pos_y      = rand_pos();
    pick          = $urandom_range(0, 99);
    if (pick < 4) begin
      ev.func = mcrg_pkg::FuncRelease;
    end else if (pick < 7) begin
      ev.action = ActIgnored;
    end else if (pick < 37) begin
      ev.action = mcrg_pkg::ActDown;
      if ($urandom_range(0, 3) == 0) ev.contact_id = pick_live_id();
    end else if (pick < 72) begin
      ev.action     = mcrg_pkg::ActMove;
      ev.contact_id = pick_live_id();
    end else if (pick < 90) begin
      ev.action     = mcrg_pkg::ActUp;
      ev.contact_id = pick_live_id();
    end else if (pick < 95) begin
      ev.action = mcrg_pkg::ActUp;
    end else begin
      ev.action = mcrg_pkg::ActMove;
    end
    return ev;
  endfunction

  // present one event beat and wait for it to be taken
  task automatic offer_event(input touch_evt_t ev, output int n);
    evt.valid      <= 1'b1;
    evt.func       <= ev.func;
    evt.action     <= ev.action;
    evt.contact_id <= ev.contact_id;
    evt.pos_x      <= ev.pos_x;
    evt.pos_y      <= ev.pos_y;
    @(posedge clk_i);
    while (!evt.ready) @(posedge clk_i);
    n = touch_to_reports(ev);
  endtask

  task automatic maybe_idle_evt();
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      evt.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [mcrg_pkg::CfgIdxW-1:0] idx,
                           input logic [mcrg_pkg::CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == mcrg_pkg::CfgRotation) cur_rot = data[mcrg_pkg::RotW-1:0];
    else cur_cmax = data;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait for all reports, then let any ignored event drain
  task automatic settle();
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // report sink: check beats, drive ready with idle bursts and the long hold
  initial begin
    contact_rpt_t want;
    int           hold_left;
    int           idle_left;
    hold_left = 0;
    idle_left = 0;
    rpt.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rpt.valid && rpt.ready) begin
        if (pending_reports.size() == 0) begin
          flag_mismatch("report with nothing pending, id", 32'(rpt.report_id), 0);
        end else begin
          want = pending_reports.pop_front();
          if (rpt.tip !== want.tip)
            flag_mismatch("tip", 32'(rpt.tip), 32'(want.tip));
          if (rpt.report_id !== want.report_id)
            flag_mismatch("report_id", 32'(rpt.report_id), 32'(want.report_id));
          if (rpt.hid_x !== want.hid_x)
            flag_mismatch("hid_x", 32'(rpt.hid_x), 32'(want.hid_x));
          if (rpt.hid_y !== want.hid_y)
            flag_mismatch("hid_y", 32'(rpt.hid_y), 32'(want.hid_y));
          if (rpt.active_count !== want.active_count)
            flag_mismatch("active_count", 32'(rpt.active_count),
                          32'(want.active_count));
          if (rpt.last !== want.last)
            flag_mismatch("last", 32'(rpt.last), 32'(want.last));
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        rpt.ready <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        rpt.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        idle_left = $urandom_range(1, 4) - 1;
        rpt.ready <= 1'b0;
      end else begin
        rpt.ready <= 1'b1;
      end
    end
  end

  // event source and run sequence
  initial begin
    touch_evt_t ev;
    int         n;
    int         done;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= mcrg_pkg::CfgRotation;
    cfg_data_i     <= '0;
    evt.valid      <= 1'b0;
    evt.func       <= mcrg_pkg::FuncTouch;
    evt.action     <= mcrg_pkg::ActDown;
    evt.contact_id <= '0;
    evt.pos_x      <= '0;
    evt.pos_y      <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table under reset settings
    for (int i = 0; i < DirRows; i++) begin
      maybe_idle_evt();
      offer_event(DirTable[i].ev, n);
      if (DirTable[i].typed)
        pending_reports[pending_reports.size()-n] = DirTable[i].want;
    end
    evt.valid <= 1'b0;

    // random phases, each under its own register setting
    for (int p = 0; p < NumPhases; p++) begin
      settle();
      case (p)
        0: begin
          write_reg(mcrg_pkg::CfgRotation, {14'b0, mcrg_pkg::Rot90});
          write_reg(mcrg_pkg::CfgCoordMax, 16'hFFFF);
        end
        1: begin
          write_reg(mcrg_pkg::CfgRotation, {14'b0, mcrg_pkg::Rot180});
          write_reg(mcrg_pkg::CfgCoordMax, 16'd1);
        end
        2: begin
          write_reg(mcrg_pkg::CfgRotation, {14'b0, mcrg_pkg::Rot270});
          write_reg(mcrg_pkg::CfgCoordMax, 16'd0);
        end
        3: begin
          write_reg(mcrg_pkg::CfgRotation, 16'($urandom_range(0, 3)));
          write_reg(mcrg_pkg::CfgCoordMax, 16'($urandom_range(1, 65535)));
        end
        default: begin
          write_reg(mcrg_pkg::CfgRotation, {14'b0, mcrg_pkg::Rot0});
          write_reg(mcrg_pkg::CfgCoordMax, 16'($urandom_range(1, 65535)));
        end
      endcase
      // no idle bursts in phase 1 and the closing phase
      gaps_on = (p != 1) && (p != NumPhases - 1);
      // long report stall while events keep coming
      if (p == 3) hold_req = 1'b1;
      done = 0;
      while (done < PhaseItems) begin
        ev = rand_event();
        maybe_idle_evt();
        offer_event(ev, n);
        if (!(ev.func == mcrg_pkg::FuncTouch && ev.action == ActIgnored)) done++;
      end
      evt.valid <= 1'b0;
    end

    settle();
    if (mismatches == 0)
      $display("multitouch_contact_report_generator verification clean");
    else
      $display("multitouch_contact_report_generator verification failed");
    $finish;
  end

endmodule
